/* hw/rtl/spim_pkg.sv */
// Shared types, codes and sizes of the SPI master core.
package spim_pkg;

    localparam int DATA_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int OP_W        = 3;
    localparam int BYTE_W      = 8;
    localparam int HALF_W      = 16;
    localparam int MODE_W      = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // operation codes on the input word
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_SEND = 3'd1;
    localparam logic [OP_W-1:0] OP_RECV = 3'd2;
    localparam logic [OP_W-1:0] OP_XFER = 3'd3;
    localparam logic [OP_W-1:0] OP_CS   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPI_MODE    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 8'd1;

    typedef enum logic [1:0] {
        ACT_IDLE,
        ACT_SEND,
        ACT_RECV,
        ACT_XFER
    } act_t;

    // classified command, one per tick
    typedef struct packed {
        logic               start;
        act_t               act;
        logic               set_cs;
        logic               cs_level;
        logic [BYTE_W-1:0]  tx_byte;
        logic               miso;
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

endpackage

/* hw/rtl/spi_master_four_modes_core.sv */
// Top level of the tick-level SPI master, SPI modes 0 to 3.
//
// Each input word is one tick of the SPI shifter: an operation in s_tuser
// (none, send, receive, transfer, set chip select; unused codes act as none)
// plus the byte to send, the chip select level and the sampled MISO pin in
// s_tdata. Every input word yields exactly one output word carrying the pin
// levels (SCK, MOSI, chip select) and status after that tick, in order. The
// core accepts one word per clock cycle while the output side keeps up; when
// m_tready is low the queue fills and s_tready drops. An accepted word is
// written into the front queue, popped by the back end, and its result word is
// registered in the output word register, which holds it until taken. The
// rate is set by the back end, which applies one tick of shifter state per
// cycle in which it pops a word. A front end classifies each word and writes
// it into a two-entry queue, so the input keeps flowing until it is full.
// Words are DATA_BITS wide, shifted MSB first; each bit takes two half
// periods of half_period ticks (zero counts as one). Commands arriving while a
// word is in progress, including chip select, are ignored. Configuration:
// index 0 is spi_mode (bit 1 CPOL, bit 0 CPHA, also drives SCK to the new
// CPOL at once), index 1 is half_period; other indexes are dropped. Write
// configuration only while the core is idle with all output words taken.
module spi_master_four_modes_core #(
    parameter int DATA_BITS   = spim_pkg::DATA_BITS_DEF,
    parameter int QUEUE_DEPTH = spim_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] tx_byte, [8] cs_level, [9] miso, [15:10] zero
    input  logic [spim_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] operation
    input  logic [spim_pkg::OP_W-1:0]         s_tuser,

    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] sck, [1] mosi, [2] chip_select, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [15:13] zero
    output logic [spim_pkg::M_TDATA_W-1:0]    m_tdata,

    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spim_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spim_pkg::*;

    cmd_t    front_cmd;
    cmd_t    back_cmd;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;
    cfg_wr_t cfg_wr;

    // registers always take a write
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    spim_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    spim_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (back_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    spim_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr      (cfg_wr),
        .q_not_empty (q_not_empty),
        .q_cmd       (back_cmd),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* hw/rtl/spim_front.sv */
// Front end: take input words and classify the operation into a command.
module spim_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spim_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [spim_pkg::OP_W-1:0]       s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output spim_pkg::cmd_t                  q_cmd
);
    import spim_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd          = '0;
        q_cmd.act      = ACT_IDLE;
        q_cmd.tx_byte  = s_tdata[BYTE_W-1:0];
        q_cmd.cs_level = s_tdata[BYTE_W];
        q_cmd.miso     = s_tdata[BYTE_W+1];
        case (s_tuser)
            OP_SEND: begin
                q_cmd.start = 1'b1;
                q_cmd.act   = ACT_SEND;
            end
            OP_RECV: begin
                q_cmd.start = 1'b1;
                q_cmd.act   = ACT_RECV;
            end
            OP_XFER: begin
                q_cmd.start = 1'b1;
                q_cmd.act   = ACT_XFER;
            end
            OP_CS: begin
                q_cmd.set_cs = 1'b1;
            end
            default: begin
                // none and unused codes: plain tick
                q_cmd.start = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/spim_queue.sv */
// Short register queue between front and back end.
module spim_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/spim_back.sv */
// Back end: shift engine, configuration registers and output word register.
module spim_back #(
    parameter int DATA_BITS = spim_pkg::DATA_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  spim_pkg::cfg_wr_t               cfg_wr,
    input  logic                            q_not_empty,
    input  spim_pkg::cmd_t                  q_cmd,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spim_pkg::M_TDATA_W-1:0]  m_tdata
);
    import spim_pkg::*;

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    logic [MODE_W-1:0]    mode_reg;
    logic [HALF_W-1:0]    hp_reg;
    logic [DATA_BITS-1:0] tx_reg, tx_next;
    logic [DATA_BITS-1:0] rx_reg, rx_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [HALF_W-1:0]    half_cnt_reg, half_cnt_next;
    logic                 bit_half_reg, bit_half_next;
    act_t                 act_reg, act_next;
    logic                 sck_reg, sck_next;
    logic                 mosi_reg, mosi_next;
    logic                 cs_reg, cs_next;
    logic                 done_c;
    logic [BYTE_W-1:0]    rx_out_c;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 cpol, cpha;
    logic [HALF_W-1:0]    hp_eff;

    assign cpol     = mode_reg[1];
    assign cpha     = mode_reg[0];
    assign hp_eff   = (hp_reg == '0) ? HALF_W'(1) : hp_reg;
    assign q_pop    = q_not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        tx_next       = tx_reg;
        rx_next       = rx_reg;
        bit_cnt_next  = bit_cnt_reg;
        half_cnt_next = half_cnt_reg;
        bit_half_next = bit_half_reg;
        act_next      = act_reg;
        sck_next      = sck_reg;
        mosi_next     = mosi_reg;
        cs_next       = cs_reg;
        done_c        = 1'b0;
        rx_out_c      = '0;

        if (act_reg == ACT_IDLE) begin
            if (q_cmd.start) begin
                // load the word and open bit 0 on the same tick
                act_next      = q_cmd.act;
                rx_next       = '0;
                bit_cnt_next  = '0;
                if (q_cmd.act != ACT_RECV) begin
                    mosi_next = q_cmd.tx_byte[DATA_BITS > BYTE_W ? 0 : DATA_BITS-1]
                                & (DATA_BITS <= BYTE_W);
                end
                tx_next       = DATA_BITS'(q_cmd.tx_byte) << 1;
                if (cpha) begin
                    sck_next  = !cpol;
                end
                half_cnt_next = '0;
                bit_half_next = 1'b0;
            end else if (q_cmd.set_cs) begin
                cs_next = q_cmd.cs_level;
            end
        end else begin
            half_cnt_next = half_cnt_reg + 1'b1;
            if (half_cnt_next >= hp_eff) begin
                half_cnt_next = '0;
                if (!bit_half_reg) begin
                    // leading or trailing edge in mid-bit, sample here
                    sck_next = cpha ? cpol : !cpol;
                    if (act_reg != ACT_SEND) begin
                        rx_next = {rx_reg[DATA_BITS-2:0], q_cmd.miso};
                    end
                    bit_half_next = 1'b1;
                end else begin
                    if (!cpha) begin
                        sck_next = cpol;
                    end
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_next >= CNT_W'(DATA_BITS)) begin
                        done_c = 1'b1;
                        if (act_reg != ACT_SEND) begin
                            rx_out_c = BYTE_W'(rx_reg);
                        end
                        act_next      = ACT_IDLE;
                        bit_cnt_next  = '0;
                        bit_half_next = 1'b0;
                    end else begin
                        // next bit: drive MSB, advance the shifter
                        if (act_reg != ACT_RECV) begin
                            mosi_next = tx_reg[DATA_BITS-1];
                        end
                        tx_next = tx_reg << 1;
                        if (cpha) begin
                            sck_next = !cpol;
                        end
                        bit_half_next = 1'b0;
                    end
                end
            end
        end

        m_tdata_next = '0;
        m_tdata_next[0]                 = sck_next;
        m_tdata_next[1]                 = mosi_next;
        m_tdata_next[2]                 = cs_next;
        m_tdata_next[3]                 = (act_next != ACT_IDLE);
        m_tdata_next[4]                 = done_c;
        m_tdata_next[5 +: BYTE_W]       = rx_out_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= '0;
            hp_reg       <= HALF_W'(1);
            tx_reg       <= '0;
            rx_reg       <= '0;
            bit_cnt_reg  <= '0;
            half_cnt_reg <= '0;
            bit_half_reg <= 1'b0;
            act_reg      <= ACT_IDLE;
            sck_reg      <= 1'b0;
            mosi_reg     <= 1'b1;
            cs_reg       <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                tx_reg       <= tx_next;
                rx_reg       <= rx_next;
                bit_cnt_reg  <= bit_cnt_next;
                half_cnt_reg <= half_cnt_next;
                bit_half_reg <= bit_half_next;
                act_reg      <= act_next;
                mosi_reg     <= mosi_next;
                cs_reg       <= cs_next;
            end
            // a mode write drives SCK to the new polarity at once
            if (cfg_wr.valid && cfg_wr.index == CFG_SPI_MODE) begin
                sck_reg <= cfg_wr.data[1];
            end else if (q_pop) begin
                sck_reg <= sck_next;
            end
            m_tvalid_reg <= q_pop || (m_tvalid_reg && !m_tready);
            if (cfg_wr.valid) begin
                if (cfg_wr.index == CFG_SPI_MODE) begin
                    mode_reg <= cfg_wr.data[MODE_W-1:0];
                end else if (cfg_wr.index == CFG_HALF_PERIOD) begin
                    hp_reg <= cfg_wr.data[HALF_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

`ifndef SYNTHESIS
    a_done_ends_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && done_c) |=> (act_reg == ACT_IDLE))
        else $error("word did not end on done tick");

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (act_reg == ACT_IDLE) |-> (bit_cnt_reg == '0 && half_cnt_reg == '0 && !bit_half_reg))
        else $error("bit counters not cleared while idle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !q_pop)
        else $error("held output word overwritten");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg < CNT_W'(DATA_BITS))
        else $error("bit count out of range");
`endif

endmodule
